[sv/dbc_pkg.sv]
// shared types and constants for the per-bit debounce and change latch
`default_nettype none
package dbc_pkg;

  localparam int BUTTON_COUNT_DEF = 16;
  localparam int RAW_W            = 16;
  localparam int PLANE_W          = 16;
  localparam int CNT_W            = 8;
  localparam int BYTE_W           = 8;

  localparam logic [CNT_W-1:0] THRESH_RESET = 8'h04;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  // per-step control handed to every button cell
  typedef struct packed {
    logic             step;
    logic [CNT_W-1:0] threshold;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/dbc_bit_cell.sv]
// one button: candidate bit, stable counter and debounced live bit
`default_nettype none
module dbc_bit_cell (
  input  logic               clk,
  input  logic               rst,
  input  dbc_pkg::cell_ctrl_t ctrl,
  input  logic               raw_bit,
  output logic               live_bit,
  output logic               commit
);
  import dbc_pkg::*;

  logic             cand;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic             live;

  assign cnt_inc  = cnt + {{(CNT_W-1){1'b0}}, 1'b1};
  assign commit   = (raw_bit == cand) && (raw_bit != live) && (cnt_inc >= ctrl.threshold);
  assign live_bit = live;

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= 1'b0;
      cnt  <= '0;
      live <= 1'b0;
    end else if (ctrl.step) begin
      priority if (raw_bit != cand) begin
        cand <= raw_bit;
        cnt  <= '0;
      end else if (raw_bit != live) begin
        if (commit) begin
          live <= raw_bit;
          cnt  <= '0;
        end else begin
          cnt <= cnt_inc;
        end
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[sv/per_bit_debounce_change_latch_core.sv]
// top level: input register, byte remap, button cells, change latch and result register
// an accepted item passes through the input register, then the result register that presents it
// one item per cycle while results are taken; the input register refills while a result waits
// a stalled output holds one result in the output register and one item in the input register
// reset (synchronous, active high) clears live state, candidates, counters, mask and irq
// reset sets the debounce threshold to 4 and empties both registers
`default_nettype none
module per_bit_debounce_change_latch_core #(
  parameter int BUTTON_COUNT = dbc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [dbc_pkg::RAW_W-1:0]   raw_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        any_changed,
  output logic                        irq_pending,
  output logic [dbc_pkg::PLANE_W-1:0] event_plane,
  output logic [dbc_pkg::PLANE_W-1:0] change_plane,
  output logic [dbc_pkg::PLANE_W-1:0] live_buttons,
  input  logic                        cfg_wr_en,
  input  logic [dbc_pkg::CNT_W-1:0]   cfg_wr_data
);
  import dbc_pkg::*;

  localparam int NBYTES = (BUTTON_COUNT + BYTE_W - 1) / BYTE_W;

  // input register
  logic             in_q_valid;
  cmd_t             cmd_q;
  logic [RAW_W-1:0] raw_q;
  logic             adv;

  // debounce threshold register
  logic [CNT_W-1:0] thr;

  // button state and change latch
  logic [BUTTON_COUNT-1:0] raw_map;
  logic [BUTTON_COUNT-1:0] live_vec;
  logic [BUTTON_COUNT-1:0] commit_vec;
  logic [BUTTON_COUNT-1:0] live_next;
  logic [BUTTON_COUNT-1:0] change_mask;
  logic [BUTTON_COUNT-1:0] change_mask_next;
  logic                    irq_flag;
  logic                    irq_flag_next;
  logic                    any_commit;
  cell_ctrl_t              ctrl;

  // planes fitted to the port width
  logic [PLANE_W-1:0] live_fit;
  logic [PLANE_W-1:0] live_next_fit;
  logic [PLANE_W-1:0] mask_fit;

  // result register
  logic               res_valid;
  logic               res_any;
  logic               res_irq;
  logic [PLANE_W-1:0] res_event;
  logic [PLANE_W-1:0] res_change;
  logic [PLANE_W-1:0] res_live;

  // the item in the input register moves on when the result register is empty or its result is taken
  assign adv      = in_q_valid && (!res_valid || out_ready);
  assign in_ready = !in_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= cmd_t'(cmd);
      raw_q <= raw_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // byte order reversal: byte k of the raw word lands in byte NBYTES-1-k,
  // bits from beyond the raw word read as zero
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_remap
    localparam int SRC = (NBYTES - 1 - i / BYTE_W) * BYTE_W + (i % BYTE_W);
    if (SRC < RAW_W) begin : g_src
      assign raw_map[i] = raw_q[SRC];
    end else begin : g_zero
      assign raw_map[i] = 1'b0;
    end
  end

  // cells only step on a sample; a read leaves every button untouched
  assign ctrl = {adv && (cmd_q == CMD_SAMPLE), thr};

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_cell
    dbc_bit_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .raw_bit  (raw_map[i]),
      .live_bit (live_vec[i]),
      .commit   (commit_vec[i])
    );
  end

  assign any_commit = |commit_vec;
  // a commit always flips its live bit
  assign live_next  = live_vec ^ commit_vec;

  // change latch: a sample accumulates commits, a read latches the live state
  // and clears mask and irq (live and latch agree right after the read)
  always_comb begin
    change_mask_next = change_mask;
    irq_flag_next    = irq_flag;
    if (adv) begin
      unique case (cmd_q)
        CMD_SAMPLE: begin
          change_mask_next = change_mask | commit_vec;
          irq_flag_next    = irq_flag | any_commit;
        end
        CMD_READ: begin
          change_mask_next = '0;
          irq_flag_next    = 1'b0;
        end
        default: begin
          change_mask_next = change_mask;
          irq_flag_next    = irq_flag;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_mask <= '0;
      irq_flag    <= 1'b0;
    end else begin
      change_mask <= change_mask_next;
      irq_flag    <= irq_flag_next;
    end
  end

  // fit button vectors to the plane width, zero above the button count
  for (genvar b = 0; b < PLANE_W; b++) begin : g_fit
    if (b < BUTTON_COUNT) begin : g_bit
      assign live_fit[b]      = live_vec[b];
      assign live_next_fit[b] = live_next[b];
      assign mask_fit[b]      = change_mask[b];
    end else begin : g_pad
      assign live_fit[b]      = 1'b0;
      assign live_next_fit[b] = 1'b0;
      assign mask_fit[b]      = 1'b0;
    end
  end

  // result register: loads on advance, empties when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_irq <= irq_flag_next;
      unique case (cmd_q)
        CMD_SAMPLE: begin
          res_any    <= any_commit;
          res_event  <= '0;
          res_change <= '0;
          res_live   <= live_next_fit;
        end
        CMD_READ: begin
          res_any    <= 1'b0;
          res_event  <= live_fit;
          res_change <= mask_fit;
          res_live   <= live_fit;
        end
        default: begin
          res_any    <= 1'b0;
          res_event  <= '0;
          res_change <= '0;
          res_live   <= live_fit;
        end
      endcase
    end
  end

  assign out_valid    = res_valid;
  assign any_changed  = res_any;
  assign irq_pending  = res_irq;
  assign event_plane  = res_event;
  assign change_plane = res_change;
  assign live_buttons = res_live;

  // a read always leaves the interrupt cleared
  a_read_clears_irq: assert property (@(posedge clk) disable iff (rst)
    (adv && (cmd_q == CMD_READ)) |=> !irq_flag)
    else $error("irq still set after a read");

  // pending changes always come with a pending interrupt
  a_mask_implies_irq: assert property (@(posedge clk) disable iff (rst)
    (|change_mask) |-> irq_flag)
    else $error("change mask set without irq");

  // live state only moves on a sample step
  a_live_only_on_sample: assert property (@(posedge clk) disable iff (rst)
    !ctrl.step |=> $stable(live_vec))
    else $error("live state changed without a sample");

  // a reported change is always reported with the interrupt raised
  a_change_raises_irq: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_any) |-> res_irq)
    else $error("change reported without irq");

  // the input register never holds an item it cannot pass on while the result is free
  a_no_stuck_item: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !res_valid) |-> adv)
    else $error("item held although result register is empty");

endmodule
`default_nettype wire

[tb/testbench.sv]
// self-checking bench for the per-bit debounce and change latch core
`default_nettype none
module testbench;
  import dbc_pkg::*;

  // one result as the block presents it
  typedef struct packed {
    logic               any_changed;
    logic               irq_pending;
    logic [PLANE_W-1:0] event_plane;
    logic [PLANE_W-1:0] change_plane;
    logic [PLANE_W-1:0] live_buttons;
  } button_result_t;

  // debounce predictor plus the queue of results still owed by the block
  class debounce_scoreboard;
    logic [PLANE_W-1:0] live;
    logic [PLANE_W-1:0] candidate;
    logic [CNT_W-1:0]   counts [PLANE_W];
    logic [PLANE_W-1:0] change_mask;
    logic [PLANE_W-1:0] latch;
    logic               irq;
    logic [CNT_W-1:0]   threshold;
    button_result_t     owed_q[$];
    int                 mismatches;
    int                 samples;
    int                 reads;
    int                 commits;

    function new();
      live        = '0;
      candidate   = '0;
      change_mask = '0;
      latch       = '0;
      irq         = 1'b0;
      threshold   = THRESH_RESET;
      foreach (counts[i]) counts[i] = '0;
      mismatches  = 0;
      samples     = 0;
      reads       = 0;
      commits     = 0;
    endfunction

    function void set_threshold(logic [CNT_W-1:0] value);
      threshold = value;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    // work out what an accepted item must produce
    function void note_item(cmd_t c, logic [RAW_W-1:0] word);
      button_result_t exp;
      logic [PLANE_W-1:0] raw;
      logic rb;
      logic lb;
      exp = '0;
      if (c == CMD_SAMPLE) begin
        // byte swap so bit n is button n
        raw = {word[BYTE_W-1:0], word[RAW_W-1:BYTE_W]};
        for (int i = 0; i < PLANE_W; i++) begin
          rb = raw[i];
          lb = live[i];
          if (rb != candidate[i]) begin
            candidate[i] = rb;
            counts[i] = '0;
          end else if (rb != lb) begin
            counts[i] = counts[i] + 1'b1;
            if (counts[i] >= threshold) begin
              live[i] = rb;
              change_mask[i] = 1'b1;
              counts[i] = '0;
              irq = 1'b1;
              exp.any_changed = 1'b1;
            end
          end else begin
            counts[i] = '0;
          end
        end
        samples++;
      end else begin
        latch = live;
        exp.event_plane  = latch;
        exp.change_plane = change_mask;
        change_mask = '0;
        irq = 1'b0;
        reads++;
      end
      exp.irq_pending  = irq;
      exp.live_buttons = live;
      owed_q.push_back(exp);
    endfunction

    function void compare_field(string name, logic [PLANE_W-1:0] want,
                                logic [PLANE_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(button_result_t got);
      button_result_t exp;
      if (owed_q.size() == 0) begin
        $error("result with nothing expected: live_buttons 0x%0h", got.live_buttons);
        mismatches++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.any_changed === 1'b1) commits++;
      compare_field("any_changed", PLANE_W'(exp.any_changed), PLANE_W'(got.any_changed));
      compare_field("irq_pending", PLANE_W'(exp.irq_pending), PLANE_W'(got.irq_pending));
      compare_field("event_plane", exp.event_plane, got.event_plane);
      compare_field("change_plane", exp.change_plane, got.change_plane);
      compare_field("live_buttons", exp.live_buttons, got.live_buttons);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_SAMPLE;
  logic [RAW_W-1:0]   raw_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               any_changed;
  logic               irq_pending;
  logic [PLANE_W-1:0] event_plane;
  logic [PLANE_W-1:0] change_plane;
  logic [PLANE_W-1:0] live_buttons;
  logic               cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;

  // idle odds out of a hundred for each side, changed per phase
  int send_idle = 7;
  int recv_idle = 67;
  int settings_used = 0;

  logic [RAW_W-1:0] held_word = '0;

  debounce_scoreboard sb = new();

  per_bit_debounce_change_latch_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .raw_word     (raw_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .any_changed  (any_changed),
    .irq_pending  (irq_pending),
    .event_plane  (event_plane),
    .change_plane (change_plane),
    .live_buttons (live_buttons),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // present one item, with random idle cycles first, and hold it until taken
  task automatic send_item(input cmd_t c, input logic [RAW_W-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    raw_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(c, w);
  endtask

  // drop valid and hold off until every owed result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // the threshold is only changed with the block fully drained
  task automatic write_threshold(input logic [CNT_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value);
    settings_used++;
  endtask

  task automatic send_samples(input logic [RAW_W-1:0] w, input int count);
    for (int k = 0; k < count; k++) send_item(CMD_SAMPLE, w);
  endtask

  // mostly held words long enough to commit, plus short holds, reads and noise
  task automatic run_random(input int n_items);
    int done;
    int pick;
    int need;
    int hold;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      need = (sb.threshold == 0) ? 1 : int'(sb.threshold);
      if (pick < 65) begin
        // new target: either fresh or a few bits moved from the last one
        if ($urandom_range(1) == 1)
          held_word = RAW_W'($urandom());
        else
          held_word = held_word ^ RAW_W'($urandom() & $urandom() & $urandom());
        // some holds are cut short so the counters are abandoned mid-way
        if ($urandom_range(99) < 15)
          hold = $urandom_range(need, 1);
        else
          hold = need + 1 + $urandom_range(2);
        for (int k = 0; k < hold && done < n_items; k++) begin
          send_item(CMD_SAMPLE, held_word);
          done++;
          if ($urandom_range(99) < 3) begin
            send_item(CMD_READ, RAW_W'($urandom()));
            done++;
          end
        end
        if ($urandom_range(99) < 70) begin
          send_item(CMD_READ, RAW_W'($urandom()));
          done++;
        end
      end else if (pick < 80) begin
        send_item(CMD_READ, RAW_W'($urandom()));
        done++;
      end else begin
        // glitch noise between the held words
        hold = $urandom_range(4, 1);
        for (int k = 0; k < hold && done < n_items; k++) begin
          send_item(CMD_SAMPLE, RAW_W'($urandom()));
          done++;
        end
      end
      // occasional full hold-off on the sender side
      if ($urandom_range(99) < 2) drain();
    end
  endtask

  // result side: check whatever is taken, then pick ready for the next edge
  initial begin
    button_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.any_changed  = any_changed;
        got.irq_pending  = irq_pending;
        got.event_plane  = event_plane;
        got.change_plane = change_plane;
        got.live_buttons = live_buttons;
        sb.check_result(got);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset threshold of four
    send_item(CMD_READ, 16'hFFFF);
    send_samples(16'hFFFF, 5);
    send_item(CMD_READ, 16'h0000);
    // second read after the first cleared the mask
    send_item(CMD_READ, 16'hA5A5);
    // byte swap check: low raw byte lands on the high buttons
    send_samples(16'h00FF, 5);
    send_item(CMD_READ, 16'h0000);
    // leave a count in progress, then lower the threshold
    send_samples(16'h1234, 3);
    write_threshold(8'd1);
    send_item(CMD_SAMPLE, 16'h1234);
    send_item(CMD_READ, 16'h0000);
    // a threshold of zero commits on the first counted sample
    write_threshold(8'd0);
    send_samples(16'h0000, 2);
    send_item(CMD_READ, 16'hFFFF);

    // random part, sender idling lightly and receiver heavily
    send_idle = 7;
    recv_idle = 67;
    write_threshold(8'd1);
    run_random(150);
    write_threshold(8'd255);
    run_random(300);

    // the other way round
    send_idle = 67;
    recv_idle = 7;
    write_threshold(8'd0);
    run_random(100);
    write_threshold(8'd7);
    run_random(100);

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;
    write_threshold(8'd2);
    run_random(120);
    write_threshold(8'd64);
    run_random(100);

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d samples and %0d reads, %0d results with a committed change",
             sb.samples, sb.reads, sb.commits);
    $display("threshold written %0d times, from zero up to 255", settings_used);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
